[design/assert_macros.svh]
// Assertion macros shared by the relay controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define DTR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("relay controller check failed");
// Checked property that also holds during reset.
`define DTR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("relay controller check failed");
`else
`define DTR_ASSERT(label, clk, rst, prop)
`define DTR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[design/dtrc_pkg.sv]
// Shared constants, codes and types of the relay controller.
package dtrc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int NUM_BUTTONS  = 4;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DRIVE_N      = (NUM_CHANNELS < NUM_BUTTONS) ? NUM_CHANNELS : NUM_BUTTONS;
  localparam int TIMER_W      = 16;
  localparam int VALUE_W      = 8;
  localparam int COUNT_W      = 9;

  localparam logic [TIMER_W-1:0] PRESS_CONFIRM_RESET   = 16'd50;
  localparam logic [TIMER_W-1:0] RELEASE_LOCKOUT_RESET = 16'd1000;

  // Input item kinds.
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Remote command modes.
  localparam logic MODE_RELAY = 1'b0;
  localparam logic MODE_IR    = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRESS_CONFIRM   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_LOCKOUT = 2'd1;
  localparam logic [1:0] CFG_BUTTONS_ENABLED = 2'd2;

  // Debouncer phases; the unused code behaves as idle.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LOCK  = 2'd1,
    PH_ARMED = 2'd3
  } phase_t;

  // Per-tick control handed to each button debouncer.
  typedef struct packed {
    logic               step;
    logic               level;
    logic [TIMER_W-1:0] confirm_ticks;
    logic [TIMER_W-1:0] lockout_ticks;
  } btn_ctl_t;

endpackage

[design/dtrc_button.sv]
// Debouncer for one pushbutton: idle, armed and lockout phases.
`include "assert_macros.svh"
module dtrc_button import dtrc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  btn_ctl_t ctl,
  output logic     toggle
);

  phase_t             phase;
  phase_t             phase_next;
  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;

  always_comb begin
    phase_next = phase;
    timer_next = timer;
    if (ctl.step) begin
      unique case (phase)
        PH_LOCK: begin
          if (timer >= ctl.lockout_ticks) begin
            if (ctl.level) begin
              phase_next = PH_IDLE;
              timer_next = '0;
            end
          end else begin
            timer_next = timer + 1'b1;
          end
        end
        PH_ARMED: begin
          if (ctl.level) begin
            phase_next = PH_IDLE;
            timer_next = '0;
          end else if (timer >= ctl.confirm_ticks) begin
            phase_next = PH_LOCK;
            timer_next = '0;
          end else begin
            timer_next = timer + 1'b1;
          end
        end
        default: begin
          if (!ctl.level) begin
            phase_next = PH_ARMED;
            timer_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    toggle = ctl.step && (phase == PH_ARMED) && !ctl.level && (timer >= ctl.confirm_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      timer <= '0;
    end else begin
      phase <= phase_next;
      timer <= timer_next;
    end
  end

  `DTR_ASSERT(a_toggle_locks, clk, rst, toggle |=> (phase == PH_LOCK) && (timer == '0))
  `DTR_ASSERT(a_hold_without_tick, clk, rst, !ctl.step |=> $stable(phase) && $stable(timer))
  `DTR_ASSERT(a_arm_clears_timer, clk, rst, $rose(phase == PH_ARMED) |-> (timer == '0))

endmodule

[design/debounced_toggle_relay_controller_core.sv]
// Top level of the four-channel debounced toggle relay controller.
//
//   Channel | Direction | Handshake            | Contents
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall   | action, button_levels, relay_index,
//           |           |                      | command_value, command_mode
//   out     | output    | out_valid / out_stall | relay_drive, ir_strobe, ir_code,
//           |           |                      | command_rejected
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every item yields exactly one result: the item passes through the input register, where all
// channels update, and its result is held in the result register until it transfers out.
// A new item can be taken every cycle; the only limit is the result register, so the
// input stalls only while a registered item waits behind a stalled result.
// Reset is synchronous and active high; it clears the relays, the debouncers, the
// off timer, the IR latch and restores the configuration defaults.
// Configuration writes are always ready and should be issued while the block is idle.
`include "assert_macros.svh"
module debounced_toggle_relay_controller_core import dtrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Item input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [3:0]           button_levels,
  input  logic [7:0]           relay_index,
  input  logic [VALUE_W-1:0]   command_value,
  input  logic                 command_mode,
  // Result output channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           relay_drive,
  output logic                 ir_strobe,
  output logic [7:0]           ir_code,
  output logic                 command_rejected,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [TIMER_W-1:0] press_confirm_ticks;
  logic [TIMER_W-1:0] release_lockout_ticks;
  logic               buttons_enabled;

  // Input register holding one accepted item.
  logic               s1_valid;
  logic               s1_action;
  logic [3:0]         s1_levels;
  logic [7:0]         s1_index;
  logic [VALUE_W-1:0] s1_value;
  logic               s1_mode;

  // Controller state.
  logic [VALUE_W-1:0] relay_store [NUM_CHANNELS];
  logic [VALUE_W-1:0] relay_store_next [NUM_CHANNELS];
  logic [CH_W-1:0]    off_channel;
  logic [CH_W-1:0]    off_channel_next;
  logic [COUNT_W-1:0] off_countdown;
  logic [COUNT_W-1:0] off_countdown_next;
  logic               off_pending;
  logic               off_pending_next;
  logic [7:0]         ir_latch;
  logic [7:0]         ir_latch_next;

  logic               strobe_next;
  logic               rejected_next;
  logic [3:0]         drive_next;
  logic [COUNT_W-1:0] count_dec;
  logic [NUM_BUTTONS-1:0] toggle;
  logic [NUM_CHANNELS-1:0] relay_on;

  // The item in the input register is processed when the result register can take it.
  logic out_free;
  logic do_step;
  logic tick_step;

  assign out_free  = !out_valid || !out_stall;
  assign do_step   = s1_valid && out_free;
  assign tick_step = do_step && (s1_action == ACT_TICK) && buttons_enabled;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_confirm_ticks   <= PRESS_CONFIRM_RESET;
      release_lockout_ticks <= RELEASE_LOCKOUT_RESET;
      buttons_enabled       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESS_CONFIRM:   press_confirm_ticks   <= cfg_data;
        CFG_RELEASE_LOCKOUT: release_lockout_ticks <= cfg_data;
        CFG_BUTTONS_ENABLED: buttons_enabled       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or its item moves on this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_levels <= button_levels;
      s1_index  <= relay_index;
      s1_value  <= command_value;
      s1_mode   <= command_mode;
    end
  end

  // One debouncer per button; a button without a relay stays idle.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    if (i < NUM_CHANNELS) begin : g_live
      btn_ctl_t ctl;
      assign ctl.step          = tick_step;
      assign ctl.level         = s1_levels[i];
      assign ctl.confirm_ticks = press_confirm_ticks;
      assign ctl.lockout_ticks = release_lockout_ticks;
      dtrc_button u_button (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .toggle (toggle[i])
      );
    end else begin : g_none
      assign toggle[i] = 1'b0;
    end
  end

  assign count_dec = off_countdown - 1'b1;

  // Channel update for the item being processed. On a tick the off timer acts first,
  // then any confirmed press flips its relay between off and on.
  always_comb begin
    relay_store_next   = relay_store;
    off_channel_next   = off_channel;
    off_countdown_next = off_countdown;
    off_pending_next   = off_pending;
    ir_latch_next      = ir_latch;
    strobe_next        = 1'b0;
    rejected_next      = 1'b0;
    if (do_step) begin
      if (s1_action == ACT_TICK) begin
        if (off_pending) begin
          off_countdown_next = count_dec;
          if (count_dec == '0) begin
            relay_store_next[off_channel] = '0;
            off_pending_next = 1'b0;
          end
        end
        for (int ch = 0; ch < DRIVE_N; ch++) begin
          if (toggle[ch]) begin
            relay_store_next[ch] = (relay_store_next[ch] == '0) ? VALUE_W'(1) : '0;
          end
        end
      end else if (s1_mode == MODE_IR) begin
        ir_latch_next = s1_value;
        strobe_next   = 1'b1;
      end else if (s1_index >= 8'(NUM_CHANNELS)) begin
        rejected_next = 1'b1;
      end else begin
        relay_store_next[s1_index[CH_W-1:0]] = s1_value;
        // A value above one also schedules the relay to drop after value+1 ticks.
        if (s1_value > VALUE_W'(1)) begin
          off_channel_next   = s1_index[CH_W-1:0];
          off_countdown_next = {1'b0, s1_value} + 1'b1;
          off_pending_next   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    drive_next = '0;
    for (int ch = 0; ch < DRIVE_N; ch++) begin
      drive_next[ch] = |relay_store_next[ch];
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      relay_on[ch] = |relay_store[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        relay_store[ch] <= '0;
      end
      off_channel   <= '0;
      off_countdown <= '0;
      off_pending   <= 1'b0;
      ir_latch      <= '0;
    end else begin
      relay_store   <= relay_store_next;
      off_channel   <= off_channel_next;
      off_countdown <= off_countdown_next;
      off_pending   <= off_pending_next;
      ir_latch      <= ir_latch_next;
    end
  end

  // Result register; it refills in the same cycle that its contents transfer out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      relay_drive      <= drive_next;
      ir_strobe        <= strobe_next;
      ir_code          <= ir_latch_next;
      command_rejected <= rejected_next;
    end
  end

  `DTR_ASSERT(a_pending_has_count, clk, rst, off_pending |-> (off_countdown != '0))
  `DTR_ASSERT(a_relays_move_on_step, clk, rst, !do_step |=> $stable(relay_on))
  `DTR_ASSERT(a_strobe_or_reject, clk, rst, out_valid |-> !(ir_strobe && command_rejected))

endmodule

[bench/tb_debounced_toggle_relay_controller_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the debounced toggle relay controller core.
module tb_debounced_toggle_relay_controller_core;
  import dtrc_pkg::*;

  // The run is ended when this many cycles in a row pass with no transfer on any channel.
  localparam int QUIET_LIMIT = 500;
  // The cfg port has a fourth index that maps to no register; writes to it are dropped.
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [3:0] ALL_RELEASED = 4'b1111;
  localparam logic [3:0] ALL_PRESSED  = 4'b0000;

  // One input item as it travels on the in channel.
  typedef struct packed {
    logic               action;
    logic [3:0]         levels;
    logic [7:0]         index;
    logic [VALUE_W-1:0] value;
    logic               mode;
  } relay_item_t;

  // One result as it travels on the out channel.
  typedef struct packed {
    logic [3:0] drive;
    logic       strobe;
    logic [7:0] code;
    logic       rejected;
  } relay_status_t;

  logic clk = 1'b0;
  logic rst;

  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [3:0]         button_levels;
  logic [7:0]         relay_index;
  logic [VALUE_W-1:0] command_value;
  logic               command_mode;

  logic               out_valid;
  logic               out_stall;
  logic [3:0]         relay_drive;
  logic               ir_strobe;
  logic [7:0]         ir_code;
  logic               command_rejected;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [TIMER_W-1:0] cfg_data;

  debounced_toggle_relay_controller_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .button_levels    (button_levels),
    .relay_index      (relay_index),
    .command_value    (command_value),
    .command_mode     (command_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .relay_drive      (relay_drive),
    .ir_strobe        (ir_strobe),
    .ir_code          (ir_code),
    .command_rejected (command_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the controller: configuration, debouncers, relays, off timer, IR latch.
  logic [TIMER_W-1:0] conf_press;
  logic [TIMER_W-1:0] conf_lockout;
  logic               conf_buttons_on;
  phase_t             deb_phase [NUM_BUTTONS];
  logic [TIMER_W-1:0] deb_timer [NUM_BUTTONS];
  logic [VALUE_W-1:0] relay_level [NUM_CHANNELS];
  logic [CH_W-1:0]    off_slot;
  logic [COUNT_W-1:0] off_remaining;
  logic               off_armed;
  logic [7:0]         ir_held;

  // Results the block still owes, oldest first.
  relay_status_t pending_relay_status [$];

  int  fault_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  reg_writes      = 0;
  bit  idling_on       = 1'b1;
  int  stall_left      = 0;

  // Stores a relay value. Any value above 1 (re)arms the single off timer for value+1
  // ticks on that channel, replacing whatever was scheduled before.
  function automatic void latch_relay(int ch, logic [VALUE_W-1:0] v);
    relay_level[ch] = v;
    if (v > 1) begin
      off_slot      = CH_W'(ch);
      off_remaining = {1'b0, v} + 1'b1;
      off_armed     = 1'b1;
    end
  endfunction

  // Advances one button's debouncer by one tick. The unused phase code falls into the
  // idle branch, just as the block treats it.
  function automatic void step_debouncer(int b, logic high);
    case (deb_phase[b])
      PH_LOCK: begin
        if (deb_timer[b] >= conf_lockout) begin
          if (high) begin
            deb_phase[b] = PH_IDLE;
            deb_timer[b] = '0;
          end
        end else begin
          deb_timer[b] = deb_timer[b] + 1'b1;
        end
      end
      PH_ARMED: begin
        if (high) begin
          // Released before the press was confirmed: a bounce, back to idle.
          deb_phase[b] = PH_IDLE;
          deb_timer[b] = '0;
        end else if (deb_timer[b] >= conf_press) begin
          latch_relay(b, (relay_level[b] == '0) ? 8'd1 : 8'd0);
          deb_phase[b] = PH_LOCK;
          deb_timer[b] = '0;
        end else begin
          deb_timer[b] = deb_timer[b] + 1'b1;
        end
      end
      default: begin
        if (!high) begin
          deb_phase[b] = PH_ARMED;
          deb_timer[b] = '0;
        end else begin
          deb_phase[b] = PH_IDLE;
        end
      end
    endcase
  endfunction

  // Applies one item to the shadow state and returns the result the block must give.
  function automatic relay_status_t predict_relay_status(relay_item_t item);
    relay_status_t st;
    st = '0;
    if (item.action == ACT_TICK) begin
      // The off timer runs before the buttons, so a toggle on the same tick wins.
      if (off_armed) begin
        off_remaining = off_remaining - 1'b1;
        if (off_remaining == '0) begin
          relay_level[off_slot] = '0;
          off_armed = 1'b0;
        end
      end
      if (conf_buttons_on) begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (b < NUM_CHANNELS) step_debouncer(b, item.levels[b]);
        end
      end
    end else if (item.mode == MODE_IR) begin
      ir_held   = item.value;
      st.strobe = 1'b1;
    end else if (item.index >= NUM_CHANNELS) begin
      st.rejected = 1'b1;
    end else begin
      latch_relay(item.index, item.value);
    end
    for (int c = 0; c < DRIVE_N; c++) st.drive[c] = (relay_level[c] != '0);
    st.code = ir_held;
    return st;
  endfunction

  // Random item of either kind; the fields a kind ignores carry random junk.
  function automatic relay_item_t random_item();
    relay_item_t it;
    it.action = 1'($urandom_range(0, 1));
    it.levels = 4'($urandom_range(0, 15));
    it.index  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(4, 255))
                                            : 8'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       it.value = 8'd0;
      1:       it.value = 8'd1;
      2:       it.value = 8'($urandom_range(2, 12));
      default: it.value = 8'($urandom_range(0, 255));
    endcase
    it.mode = ($urandom_range(0, 3) == 0) ? MODE_IR : MODE_RELAY;
    return it;
  endfunction

  function automatic relay_item_t tick_item(logic [3:0] levels);
    relay_item_t it;
    it        = random_item();
    it.action = ACT_TICK;
    it.levels = levels;
    return it;
  endfunction

  function automatic relay_item_t command_item(logic mode, logic [7:0] index,
                                               logic [VALUE_W-1:0] value);
    relay_item_t it;
    it        = random_item();
    it.action = ACT_COMMAND;
    it.mode   = mode;
    it.index  = index;
    it.value  = value;
    return it;
  endfunction

  // Offers one item on the in channel, holding it through any stall, and books the
  // expected result once the transfer happens. Valid is left high so that a following
  // item can go out back to back; the next gap or settle lowers it.
  task automatic send_item(relay_item_t item);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    action        <= item.action;
    button_levels <= item.levels;
    relay_index   <= item.index;
    command_value <= item.value;
    command_mode  <= item.mode;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_relay_status.push_back(predict_relay_status(item));
    items_sent++;
  endtask

  // Drops valid and waits for every owed result, then waits out the tail that the caller gives.
  task automatic settle(int tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_relay_status.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // One register write; the shadow configuration follows it at the transfer.
  task automatic write_register(logic [1:0] idx, logic [TIMER_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_PRESS_CONFIRM:   conf_press      = data;
      CFG_RELEASE_LOCKOUT: conf_lockout    = data;
      CFG_BUTTONS_ENABLED: conf_buttons_on = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Remote command paths under the reset configuration: relay sets, indexes past the
  // last channel, IR latching with an out-of-range index, and the off timer firing.
  task automatic test_command_paths();
    send_item(command_item(MODE_RELAY, 8'd0, 8'd1));
    send_item(command_item(MODE_RELAY, 8'd3, 8'd1));
    send_item(command_item(MODE_RELAY, 8'd4, 8'd1));
    send_item(command_item(MODE_RELAY, 8'd255, 8'd0));
    send_item(command_item(MODE_IR, 8'd255, 8'hFF));
    send_item(command_item(MODE_IR, 8'd0, 8'd0));
    // Smallest delayed value: the relay drops on the third tick.
    send_item(command_item(MODE_RELAY, 8'd1, 8'd2));
    repeat (4) send_item(tick_item(ALL_RELEASED));
    // Largest delayed value leaves a long schedule running into the next tests.
    send_item(command_item(MODE_RELAY, 8'd2, 8'd255));
    send_item(command_item(MODE_RELAY, 8'd0, 8'd0));
  endtask

  // Debouncer edges with a zero press time and a lockout of one tick: confirm, lockout, release,
  // and a press that bounces back high before it is confirmed.
  task automatic test_debounce_edges();
    settle(2);
    write_register(CFG_PRESS_CONFIRM, 16'd0);
    write_register(CFG_RELEASE_LOCKOUT, 16'd1);
    send_item(tick_item(4'b1110));
    send_item(tick_item(4'b1110));
    send_item(tick_item(ALL_RELEASED));
    send_item(tick_item(ALL_RELEASED));
    send_item(tick_item(ALL_PRESSED));
    send_item(tick_item(ALL_RELEASED));
  endtask

  // With buttons off, held buttons must leave relays and debouncers alone. Upper data
  // bits are set on purpose; only bit 0 counts.
  task automatic test_buttons_disabled();
    settle(2);
    write_register(CFG_BUTTONS_ENABLED, 16'hFFFE);
    send_item(tick_item(ALL_PRESSED));
    send_item(tick_item(ALL_PRESSED));
    settle(2);
    write_register(CFG_BUTTONS_ENABLED, 16'h0001);
  endtask

  // Both timing registers at their top value, a write to the unmapped index, then both
  // at zero so the already armed buttons confirm on the very next tick.
  task automatic test_register_extremes();
    settle(2);
    write_register(CFG_PRESS_CONFIRM, 16'hFFFF);
    write_register(CFG_RELEASE_LOCKOUT, 16'hFFFF);
    write_register(CFG_UNMAPPED, 16'hFFFF);
    repeat (3) send_item(tick_item(ALL_PRESSED));
    settle(2);
    write_register(CFG_PRESS_CONFIRM, 16'h0000);
    write_register(CFG_RELEASE_LOCKOUT, 16'h0000);
    send_item(tick_item(ALL_PRESSED));
    send_item(tick_item(ALL_RELEASED));
  endtask

  // A well-formed button gesture: some buttons held for about the confirm time, then
  // released for about the lockout time. Lengths straddle the thresholds so that some
  // presses bounce and some releases come too early. Contact bounce and stray commands
  // are mixed in.
  task automatic run_press_sequence();
    logic [3:0] held;
    logic [3:0] lv;
    int         hold_len;
    int         free_len;
    held     = 4'($urandom_range(1, 15));
    hold_len = int'(conf_press) + $urandom_range(0, 4);
    free_len = int'(conf_lockout) + $urandom_range(0, 3);
    for (int k = 0; k < hold_len + free_len; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(random_item());
      lv = (k < hold_len) ? ~held : ALL_RELEASED;
      if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, 3)] ^= 1'b1;
      send_item(tick_item(lv));
    end
  endtask

  // Random traffic over several configuration settings, mostly button gestures. One
  // phase runs with buttons off and is kept short; one runs without idling.
  task automatic test_random_phases();
    int goal;
    for (int p = 0; p < 6; p++) begin
      settle(2);
      idling_on = (p != 3);
      write_register(CFG_PRESS_CONFIRM, 16'($urandom_range(0, 6)));
      write_register(CFG_RELEASE_LOCKOUT, 16'($urandom_range(0, 10)));
      write_register(CFG_BUTTONS_ENABLED, {15'($urandom), (p == 4) ? 1'b0 : 1'b1});
      goal = items_sent + ((p == 4) ? 20 : 65);
      while (items_sent < goal) begin
        if ($urandom_range(0, 3) != 0) run_press_sequence();
        else send_item(random_item());
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate_tail();
    int goal;
    settle(2);
    idling_on = 1'b0;
    write_register(CFG_PRESS_CONFIRM, 16'd2);
    write_register(CFG_RELEASE_LOCKOUT, 16'd3);
    write_register(CFG_BUTTONS_ENABLED, 16'd1);
    goal = items_sent + 40;
    while (items_sent < goal) begin
      if ($urandom_range(0, 2) != 0) run_press_sequence();
      else send_item(random_item());
    end
  endtask

  // The result side stalls in random bursts while idling is allowed.
  always @(negedge clk) begin
    if (!idling_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Every result transfer is matched against the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    relay_status_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_relay_status.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result %0d arrived with nothing expected: drive=%b strobe=%b code=%h rej=%b",
                   results_checked, relay_drive, ir_strobe, ir_code, command_rejected);
      end else begin
        want = pending_relay_status.pop_front();
        if (relay_drive !== want.drive || ir_strobe !== want.strobe ||
            ir_code !== want.code || command_rejected !== want.rejected) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d mismatch: expected drive=%b strobe=%b code=%h rej=%b, %s",
                     results_checked, want.drive, want.strobe, want.code, want.rejected,
                     $sformatf("got drive=%b strobe=%b code=%h rej=%b",
                               relay_drive, ir_strobe, ir_code, command_rejected));
        end
      end
    end
  end

  // Ends a hung run: counts cycles with no transfer on any channel.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("tb_debounced_toggle_relay_controller_core: done, errors");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_TICK;
    button_levels = ALL_RELEASED;
    relay_index   = '0;
    command_value = '0;
    command_mode  = MODE_RELAY;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_PRESS_CONFIRM;
    cfg_data      = '0;

    // Shadow state matches what reset leaves in the block.
    conf_press      = PRESS_CONFIRM_RESET;
    conf_lockout    = RELEASE_LOCKOUT_RESET;
    conf_buttons_on = 1'b1;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      deb_phase[b] = PH_IDLE;
      deb_timer[b] = '0;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) relay_level[c] = '0;
    off_slot      = '0;
    off_remaining = '0;
    off_armed     = 1'b0;
    ir_held       = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_command_paths();
    test_debounce_edges();
    test_buttons_disabled();
    test_register_extremes();
    test_random_phases();
    test_full_rate_tail();

    // Everything sent; wait for the last results.
    settle(4);
    if (pending_relay_status.size() != 0) begin
      fault_count += pending_relay_status.size();
      $display("%0d expected results never arrived", pending_relay_status.size());
    end

    $display("sent %0d ticks and commands over %0d register writes, checked %0d results",
             items_sent, reg_writes, results_checked);
    $display("relay sets, IR latches, off timers and debounced presses; %0d faults",
             fault_count);
    if (fault_count == 0)
      $display("tb_debounced_toggle_relay_controller_core: done, clean");
    else
      $display("tb_debounced_toggle_relay_controller_core: done, errors");
    $finish;
  end

endmodule
